FILE: rtl/kdpl_pkg.sv
// Shared types, widths and constants for the kiwi drive position loop.
package kdpl_pkg;

   // Field widths.
   localparam int DIST_W  = 24;
   localparam int CMD_W   = 16;
   localparam int ACC_W   = 32;
   localparam int SPEED_W = 15;
   localparam int THR_W   = 16;
   localparam int SCALE_W = 24;

   // Configuration port.
   localparam int ADDR_W  = 5;
   localparam int DATA_W  = 32;

   // Internal datapath widths.
   localparam int SUM_W   = DIST_W + 3;       // role combination of three deltas
   localparam int MAG_W   = DIST_W + 2;       // magnitude fed to the multiplier
   localparam int K_W     = 32;               // multiplier coefficient
   localparam int PROD_W  = MAG_W + K_W;      // full product
   localparam int DMAG_W  = 34;               // rounded delta magnitude
   localparam int DELTA_W = DMAG_W + 1;       // signed delta
   localparam int ASUM_W  = DELTA_W + 1;      // accumulator sum before saturation
   localparam int ERR_W   = ACC_W + 1;        // target minus accumulator

   // Scaling constants.
   localparam logic [K_W-1:0]    INV_SQRT3_Q16 = 32'd37837;
   localparam logic [K_W-1:0]    RECIP3        = 32'hAAAA_AAAB;
   localparam int                Q16_SHIFT     = 16;
   localparam int                RECIP3_SHIFT  = 33;
   localparam logic [PROD_W-1:0] Q16_HALF      = PROD_W'(32768);

   // Accumulator limits.
   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   // Register reset values.
   localparam logic [SPEED_W-1:0] MAX_SPEED_RST = 15'd25600;
   localparam logic [THR_W-1:0]   THRESH_RST    = 16'd256;
   localparam logic [SCALE_W-1:0] SCALE_RST     = 24'd417000;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_DRIVE  = 2'd1,
      MODE_STRAFE = 2'd2,
      MODE_ROTATE = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      AXIS_FORWARD = 2'd0,
      AXIS_LEFT    = 2'd1,
      AXIS_RIGHT   = 2'd2
   } axis_type;

   typedef enum logic [2:0] {
      REG_MOTION_MODE    = 3'd0,
      REG_AXIS_SELECT    = 3'd1,
      REG_TARGET_VALUE   = 3'd2,
      REG_MAX_SPEED      = 3'd3,
      REG_DONE_THRESHOLD = 3'd4,
      REG_ROTATION_SCALE = 3'd5
   } reg_index_type;

endpackage

FILE: rtl/kiwi_drive_position_loop_top.sv
// Top level of the kiwi drive position loop: odometry, accumulator and P control.
// An accepted input is registered in turn in stages A to E and then in the output register.
// Throughput: one item per cycle while the receiver does not stall the output, through a
// six-register pipeline; the accumulator add and saturate form the loop that sets that rate.
// Reset clears all pipeline valids, the stored wheel readings, the accumulator
// and the configuration registers to their defaults; no clearing pass is needed.
module kiwi_drive_position_loop_top
   import kdpl_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // Input channel.
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [DIST_W-1:0]  req_rear_distance,
   input  logic signed [DIST_W-1:0]  req_left_distance,
   input  logic signed [DIST_W-1:0]  req_right_distance,
   input  logic                      req_restart,
   // Result channel.
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [CMD_W-1:0]   rsp_rear_command,
   output logic signed [CMD_W-1:0]   rsp_left_command,
   output logic signed [CMD_W-1:0]   rsp_right_command,
   output logic signed [ACC_W-1:0]   rsp_travelled,
   output logic                      rsp_within_threshold,
   // Configuration port.
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [ADDR_W-1:0]         csr_paddr,
   input  logic [DATA_W-1:0]         csr_pwdata,
   output logic [DATA_W-1:0]         csr_prdata,
   output logic                      csr_pready
);

   // Configuration registers.
   mode_type                 mode_ff;
   axis_type                 axis_ff;
   logic signed [ACC_W-1:0]  target_ff;
   logic [SPEED_W-1:0]       max_speed_ff;
   logic [THR_W-1:0]         threshold_ff;
   logic [SCALE_W-1:0]       scale_ff;
   reg_index_type            csr_index;
   logic                     csr_write;

   // Pipeline valids and handshake.
   logic a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff, e_valid_ff, rsp_valid_ff;
   logic a_ready, b_ready, c_ready, d_ready, e_ready, f_ready;
   logic a_load, b_load, c_load, d_load, e_load, f_load;

   // Stage A: captured input item.
   logic signed [DIST_W-1:0] a_rear_ff, a_left_ff, a_right_ff;
   logic                     a_restart_ff;

   // Stored wheel readings.
   logic signed [DIST_W-1:0] last_rear_ff, last_left_ff, last_right_ff;

   // Stage B: role combination magnitude.
   logic signed [DIST_W-1:0] d_rear, d_left, d_right;
   logic signed [DIST_W-1:0] d_axial, d_lrole, d_rrole;
   logic signed [SUM_W-1:0]  sum_in;
   logic [SUM_W-1:0]         sum_abs;
   logic [MAG_W-1:0]         b_mag_in, b_mag_ff;
   logic                     b_neg_ff, b_restart_ff;

   // Stage C: scaled product.
   logic [K_W-1:0]           coef;
   logic [PROD_W-1:0]        c_prod_in, c_prod_ff;
   logic                     c_neg_ff, c_restart_ff;

   // Stage D: rounded signed delta.
   logic [PROD_W-1:0]        prod_round;
   logic [DMAG_W-1:0]        delta_mag;
   logic signed [DELTA_W-1:0] d_delta_in, d_delta_ff;
   logic                     d_restart_ff;

   // Stage E: accumulator and error.
   logic signed [ASUM_W-1:0] acc_sum;
   logic signed [ACC_W-1:0]  acc_sat, acc_in, acc_ff;
   logic signed [ERR_W-1:0]  e_err_in, e_err_ff;
   logic                     e_restart_ff;

   // Stage F: commands.
   logic [ERR_W-1:0]         err_mag;
   logic [ERR_W+2:0]         err_x7;
   logic [ERR_W+2:0]         lin_sum;
   logic [ERR_W+1:0]         rot_sum;
   logic [ERR_W+1:0]         raw_mag;
   logic [SPEED_W-1:0]       cmd_mag;
   logic [CMD_W-1:0]         half_sum;
   logic signed [CMD_W-1:0]  cmd_val, side_val;
   logic signed [CMD_W-1:0]  role_axial, role_left, role_right;
   logic signed [CMD_W-1:0]  rear_cmd_in, left_cmd_in, right_cmd_in;
   logic                     within_in;
   logic signed [CMD_W-1:0]  rear_cmd_ff, left_cmd_ff, right_cmd_ff;
   logic signed [ACC_W-1:0]  travelled_ff;
   logic                     within_ff;

   // ---------------------------------------------------------------
   // Configuration port
   // ---------------------------------------------------------------

   // A write transfer completes in the access phase; pready is always high.
   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[ADDR_W-1:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         axis_ff      <= AXIS_FORWARD;
         target_ff    <= '0;
         max_speed_ff <= MAX_SPEED_RST;
         threshold_ff <= THRESH_RST;
         scale_ff     <= SCALE_RST;
      end else if (csr_write) begin
         case (csr_index)
            REG_MOTION_MODE:    mode_ff      <= mode_type'(csr_pwdata[1:0]);
            REG_AXIS_SELECT:    axis_ff      <= axis_type'(csr_pwdata[1:0]);
            REG_TARGET_VALUE:   target_ff    <= $signed(csr_pwdata[ACC_W-1:0]);
            REG_MAX_SPEED:      max_speed_ff <= csr_pwdata[SPEED_W-1:0];
            REG_DONE_THRESHOLD: threshold_ff <= csr_pwdata[THR_W-1:0];
            REG_ROTATION_SCALE: scale_ff     <= csr_pwdata[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   // Register read mux.
   always_comb begin
      case (csr_index)
         REG_MOTION_MODE:    csr_prdata = DATA_W'(mode_ff);
         REG_AXIS_SELECT:    csr_prdata = DATA_W'(axis_ff);
         REG_TARGET_VALUE:   csr_prdata = DATA_W'($unsigned(target_ff));
         REG_MAX_SPEED:      csr_prdata = DATA_W'(max_speed_ff);
         REG_DONE_THRESHOLD: csr_prdata = DATA_W'(threshold_ff);
         REG_ROTATION_SCALE: csr_prdata = DATA_W'(scale_ff);
         default:            csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // Pipeline flow control
   // ---------------------------------------------------------------

   // Each stage takes a new item when it is empty or its item moves on.
   assign f_ready = !rsp_valid_ff || !rsp_stall;
   assign e_ready = !e_valid_ff || f_ready;
   assign d_ready = !d_valid_ff || e_ready;
   assign c_ready = !c_valid_ff || d_ready;
   assign b_ready = !b_valid_ff || c_ready;
   assign a_ready = !a_valid_ff || b_ready;

   assign a_load = req_valid && a_ready;
   assign b_load = a_valid_ff && b_ready;
   assign c_load = b_valid_ff && c_ready;
   assign d_load = c_valid_ff && d_ready;
   assign e_load = d_valid_ff && e_ready;
   assign f_load = e_valid_ff && f_ready;

   assign req_stall = !a_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         e_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (a_ready) a_valid_ff   <= req_valid;
         if (b_ready) b_valid_ff   <= a_valid_ff;
         if (c_ready) c_valid_ff   <= b_valid_ff;
         if (d_ready) d_valid_ff   <= c_valid_ff;
         if (e_ready) e_valid_ff   <= d_valid_ff;
         if (f_ready) rsp_valid_ff <= e_valid_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage A: input register
   // ---------------------------------------------------------------

   always_ff @(posedge clock) begin
      if (a_load) begin
         a_rear_ff    <= req_rear_distance;
         a_left_ff    <= req_left_distance;
         a_right_ff   <= req_right_distance;
         a_restart_ff <= req_restart;
      end
   end

   // ---------------------------------------------------------------
   // Stage B: wheel deltas, role mapping and combination
   // ---------------------------------------------------------------

   // Deltas wrap at the reading width.
   assign d_rear  = a_rear_ff  - last_rear_ff;
   assign d_left  = a_left_ff  - last_left_ff;
   assign d_right = a_right_ff - last_right_ff;

   // Map the physical wheels onto axial, left and right roles.
   always_comb begin
      case (axis_ff)
         AXIS_LEFT: begin
            d_axial = d_right;
            d_lrole = d_rear;
            d_rrole = d_left;
         end
         AXIS_RIGHT: begin
            d_axial = d_left;
            d_lrole = d_right;
            d_rrole = d_rear;
         end
         default: begin
            d_axial = d_rear;
            d_lrole = d_left;
            d_rrole = d_right;
         end
      endcase
   end

   // Combine the deltas for the mode; the multiplier works on the magnitude.
   always_comb begin
      case (mode_ff)
         MODE_DRIVE:  sum_in = SUM_W'(d_rrole) - SUM_W'(d_lrole);
         MODE_STRAFE: sum_in = (SUM_W'(d_axial) <<< 1) - SUM_W'(d_rrole)
                               - SUM_W'(d_lrole);
         MODE_ROTATE: sum_in = SUM_W'(d_rear) + SUM_W'(d_left) + SUM_W'(d_right);
         default:     sum_in = '0;
      endcase
      sum_abs = sum_in[SUM_W-1] ? $unsigned(-sum_in) : $unsigned(sum_in);
      // Division by three rounds by flooring the magnitude plus one.
      b_mag_in = sum_abs[MAG_W-1:0] + MAG_W'(mode_ff == MODE_STRAFE);
   end

   // The stored readings follow every item, restart or not.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_rear_ff  <= '0;
         last_left_ff  <= '0;
         last_right_ff <= '0;
      end else if (b_load) begin
         last_rear_ff  <= a_rear_ff;
         last_left_ff  <= a_left_ff;
         last_right_ff <= a_right_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_load) begin
         b_mag_ff     <= b_mag_in;
         b_neg_ff     <= sum_in[SUM_W-1];
         b_restart_ff <= a_restart_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage C: scaling multiply
   // ---------------------------------------------------------------

   always_comb begin
      case (mode_ff)
         MODE_DRIVE:  coef = INV_SQRT3_Q16;
         MODE_STRAFE: coef = RECIP3;
         MODE_ROTATE: coef = K_W'(scale_ff);
         default:     coef = '0;
      endcase
      c_prod_in = PROD_W'(b_mag_ff) * PROD_W'(coef);
   end

   always_ff @(posedge clock) begin
      if (c_load) begin
         c_prod_ff    <= c_prod_in;
         c_neg_ff     <= b_neg_ff;
         c_restart_ff <= b_restart_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage D: rounding and sign
   // ---------------------------------------------------------------

   // Round half away from zero (strafe floors a magnitude rounded in stage B), then restore the sign.
   always_comb begin
      prod_round = c_prod_ff + Q16_HALF;
      if (mode_ff == MODE_STRAFE) begin
         delta_mag = DMAG_W'(c_prod_ff[PROD_W-1:RECIP3_SHIFT]);
      end else begin
         delta_mag = prod_round[Q16_SHIFT+DMAG_W-1:Q16_SHIFT];
      end
      d_delta_in = c_neg_ff ? -$signed({1'b0, delta_mag}) : $signed({1'b0, delta_mag});
   end

   always_ff @(posedge clock) begin
      if (d_load) begin
         d_delta_ff   <= d_delta_in;
         d_restart_ff <= c_restart_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage E: saturating accumulator and error
   // ---------------------------------------------------------------

   always_comb begin
      acc_sum = ASUM_W'(acc_ff) + ASUM_W'(d_delta_ff);
      if (acc_sum[ASUM_W-1:ACC_W-1] == '0 || acc_sum[ASUM_W-1:ACC_W-1] == '1) begin
         acc_sat = acc_sum[ACC_W-1:0];
      end else if (acc_sum[ASUM_W-1]) begin
         acc_sat = ACC_MIN;
      end else begin
         acc_sat = ACC_MAX;
      end
      if (d_restart_ff) begin
         acc_in = '0;
      end else if (mode_ff == MODE_IDLE) begin
         acc_in = acc_ff;
      end else begin
         acc_in = acc_sat;
      end
      e_err_in = ERR_W'(target_ff) - ERR_W'(acc_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (e_load) begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (e_load) begin
         e_err_ff     <= e_err_in;
         e_restart_ff <= d_restart_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage F: gain, clamp and wheel commands
   // ---------------------------------------------------------------

   always_comb begin
      err_mag = e_err_ff[ERR_W-1] ? $unsigned(-e_err_ff) : $unsigned(e_err_ff);
      // Linear gain of 3.5 and rotation gain of 1/4, rounded away from zero.
      err_x7  = ((ERR_W+3)'(err_mag) << 3) - (ERR_W+3)'(err_mag);
      lin_sum = err_x7 + (ERR_W+3)'(1);
      rot_sum = (ERR_W+2)'(err_mag) + (ERR_W+2)'(2);
      if (mode_ff == MODE_ROTATE) begin
         raw_mag = (ERR_W+2)'(rot_sum[ERR_W+1:2]);
      end else begin
         raw_mag = lin_sum[ERR_W+2:1];
      end
      cmd_mag  = (raw_mag > (ERR_W+2)'(max_speed_ff)) ? max_speed_ff
                                                      : raw_mag[SPEED_W-1:0];
      cmd_val  = e_err_ff[ERR_W-1] ? -$signed({1'b0, cmd_mag})
                                   : $signed({1'b0, cmd_mag});
      // Strafe side wheels take minus half the command, rounded away from zero.
      half_sum = {1'b0, cmd_mag} + CMD_W'(1);
      side_val = e_err_ff[ERR_W-1] ? $signed({1'b0, half_sum[CMD_W-1:1]})
                                   : -$signed({1'b0, half_sum[CMD_W-1:1]});

      case (mode_ff)
         MODE_DRIVE: begin
            role_axial = '0;
            role_left  = -cmd_val;
            role_right = cmd_val;
         end
         MODE_STRAFE: begin
            role_axial = cmd_val;
            role_left  = side_val;
            role_right = side_val;
         end
         MODE_ROTATE: begin
            role_axial = cmd_val;
            role_left  = cmd_val;
            role_right = cmd_val;
         end
         default: begin
            role_axial = '0;
            role_left  = '0;
            role_right = '0;
         end
      endcase
      if (e_restart_ff) begin
         role_axial = '0;
         role_left  = '0;
         role_right = '0;
      end

      // Map roles back onto the physical wheels.
      case (axis_ff)
         AXIS_LEFT: begin
            rear_cmd_in  = role_left;
            left_cmd_in  = role_right;
            right_cmd_in = role_axial;
         end
         AXIS_RIGHT: begin
            rear_cmd_in  = role_right;
            left_cmd_in  = role_axial;
            right_cmd_in = role_left;
         end
         default: begin
            rear_cmd_in  = role_axial;
            left_cmd_in  = role_left;
            right_cmd_in = role_right;
         end
      endcase

      within_in = (mode_ff != MODE_IDLE) && (err_mag < ERR_W'(threshold_ff));
   end

   always_ff @(posedge clock) begin
      if (f_load) begin
         rear_cmd_ff  <= rear_cmd_in;
         left_cmd_ff  <= left_cmd_in;
         right_cmd_ff <= right_cmd_in;
         travelled_ff <= acc_ff;
         within_ff    <= within_in;
      end
   end

   assign rsp_rear_command     = rear_cmd_ff;
   assign rsp_left_command     = left_cmd_ff;
   assign rsp_right_command    = right_cmd_ff;
   assign rsp_travelled        = travelled_ff;
   assign rsp_within_threshold = within_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------

   // The accumulator moves only when an item enters the accumulate stage.
   a_acc_hold: assert property (@(posedge clock) disable iff (reset)
      !e_load |=> $stable(acc_ff))
      else $error("accumulator changed without an item");

   // The stored readings move only when an item leaves the input register.
   a_base_hold: assert property (@(posedge clock) disable iff (reset)
      !b_load |=> $stable(last_rear_ff) && $stable(last_left_ff) && $stable(last_right_ff))
      else $error("wheel baseline changed without an item");

   // A draining output lets every stage move, so the input is never stalled.
   a_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_stall |-> !req_stall)
      else $error("input stalled while the output drains");

   // A restart item holds the accumulator at zero until it moves on.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      e_valid_ff && e_restart_ff |-> acc_ff == '0)
      else $error("restart did not clear the accumulator");

endmodule

FILE: tb/sv/kiwi_drive_position_loop_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the kiwi drive position loop: directed rows, then random phases.
module kiwi_drive_position_loop_top_test
   import kdpl_pkg::*;
();

   localparam int QUIET_LIMIT     = 4000;
   localparam int DRAIN_CYCLES    = 20;
   localparam int RESET_CYCLES    = 11;
   localparam int PHASES          = 15;
   localparam int TICKS_PER_PHASE = 100;
   localparam int REPORT_LIMIT    = 10;
   localparam longint INV_SQRT3   = 37837;
   localparam logic [DIST_W-1:0] DIST_MAX = 24'h7FFFFF;
   localparam logic [DIST_W-1:0] DIST_MIN = 24'h800000;

   // One result transfer: the three wheel commands, the accumulator and the reach flag.
   typedef struct packed {
      logic signed [CMD_W-1:0] rear_cmd;
      logic signed [CMD_W-1:0] left_cmd;
      logic signed [CMD_W-1:0] right_cmd;
      logic signed [ACC_W-1:0] travelled;
      logic                    in_reach;
   } wheel_result_type;

   typedef enum logic [1:0] {ROW_CSR, ROW_TICK, ROW_FIXED} row_kind_type;

   typedef struct {
      row_kind_type      kind;
      reg_index_type     idx;
      logic [31:0]       value;
      logic [DIST_W-1:0] rear;
      logic [DIST_W-1:0] left;
      logic [DIST_W-1:0] right;
      logic              restart;
      wheel_result_type  known;
   } stim_row_type;

   typedef enum logic [1:0] {
      STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC
   } stall_style_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic signed [DIST_W-1:0] req_rear_distance = '0;
   logic signed [DIST_W-1:0] req_left_distance = '0;
   logic signed [DIST_W-1:0] req_right_distance = '0;
   logic                     req_restart = 1'b0;

   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [CMD_W-1:0]  rsp_rear_command;
   logic signed [CMD_W-1:0]  rsp_left_command;
   logic signed [CMD_W-1:0]  rsp_right_command;
   logic signed [ACC_W-1:0]  rsp_travelled;
   logic                     rsp_within_threshold;

   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [ADDR_W-1:0]        csr_paddr = '0;
   logic [DATA_W-1:0]        csr_pwdata = '0;
   logic [DATA_W-1:0]        csr_prdata;
   logic                     csr_pready;

   // Shadow of the block's registers and state.
   mode_type                 cfg_mode = MODE_IDLE;
   logic [1:0]               cfg_axis = 2'd0;
   logic signed [ACC_W-1:0]  cfg_target = '0;
   logic [SPEED_W-1:0]       cfg_speed_limit = MAX_SPEED_RST;
   logic [THR_W-1:0]         cfg_threshold = THRESH_RST;
   logic [SCALE_W-1:0]       cfg_scale = SCALE_RST;
   logic [DIST_W-1:0]        wheel_seen [3] = '{'0, '0, '0};
   logic signed [ACC_W-1:0]  accum = '0;

   wheel_result_type queued_results [$];
   stim_row_type     directed_rows [$];
   int               mismatches = 0;
   int               quiet_cycles = 0;
   stall_style_type  stall_style = STALL_NONE;
   logic [7:0]       stall_run = '0;

   always #2 clock = ~clock;

   kiwi_drive_position_loop_top uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_rear_distance    (req_rear_distance),
      .req_left_distance    (req_left_distance),
      .req_right_distance   (req_right_distance),
      .req_restart          (req_restart),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_rear_command     (rsp_rear_command),
      .rsp_left_command     (rsp_left_command),
      .rsp_right_command    (rsp_right_command),
      .rsp_travelled        (rsp_travelled),
      .rsp_within_threshold (rsp_within_threshold),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_prdata           (csr_prdata),
      .csr_pready           (csr_pready)
   );

   // Division rounding to nearest, ties away from zero.
   function automatic longint round_div(input longint num, input longint den);
      if (num >= 0) return (num + den / 2) / den;
      return -((-num + den / 2) / den);
   endfunction

   function automatic longint clamp_speed(input longint v);
      longint lim;
      lim = cfg_speed_limit;
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   // Advances the shadow state by one tick and returns the wheel commands it produces.
   function automatic wheel_result_type loop_tick(input logic [DIST_W-1:0] rear, left, right,
                                                  input logic restart);
      logic [DIST_W-1:0] now_pos [3];
      logic [DIST_W-1:0] diff;
      longint d [3];
      longint role [3];
      longint cmd [3];
      longint acc, step, err, c, target, mag;
      int ia, il, ir;
      wheel_result_type r;
      now_pos[0] = rear;
      now_pos[1] = left;
      now_pos[2] = right;
      for (int k = 0; k < 3; k++) begin
         diff = now_pos[k] - wheel_seen[k];
         d[k] = $signed(diff);
         wheel_seen[k] = now_pos[k];
      end

      // Wheel roles (axial, left, right); the unused axis code falls back to forward.
      ia = 0; il = 1; ir = 2;
      if (cfg_axis == AXIS_LEFT) begin
         ia = 2; il = 0; ir = 1;
      end else if (cfg_axis == AXIS_RIGHT) begin
         ia = 1; il = 2; ir = 0;
      end

      cmd = '{0, 0, 0};
      target = cfg_target;
      acc = accum;
      if (restart) begin
         acc = 0;
      end else if (cfg_mode != MODE_IDLE) begin
         case (cfg_mode)
            MODE_DRIVE:  step = round_div((d[ir] - d[il]) * INV_SQRT3, 65536);
            MODE_STRAFE: step = round_div(2 * d[ia] - d[ir] - d[il], 3);
            default:     step = round_div(longint'(cfg_scale) * (d[0] + d[1] + d[2]), 65536);
         endcase
         acc = acc + step;
         if (acc > ACC_MAX) acc = ACC_MAX;
         if (acc < ACC_MIN) acc = ACC_MIN;

         err = target - acc;
         if (cfg_mode == MODE_ROTATE) c = clamp_speed(round_div(err, 4));
         else c = clamp_speed(round_div(err * 7, 2));

         case (cfg_mode)
            MODE_DRIVE: begin
               role[0] = 0; role[1] = -c; role[2] = c;
            end
            MODE_STRAFE: begin
               role[0] = c; role[1] = round_div(-c, 2); role[2] = role[1];
            end
            default: begin
               role[0] = c; role[1] = c; role[2] = c;
            end
         endcase
         cmd[ia] = role[0];
         cmd[il] = role[1];
         cmd[ir] = role[2];
      end
      accum = acc[ACC_W-1:0];

      mag = target - acc;
      if (mag < 0) mag = -mag;
      r.in_reach  = (cfg_mode != MODE_IDLE) && (mag < longint'(cfg_threshold));
      r.rear_cmd  = cmd[0][CMD_W-1:0];
      r.left_cmd  = cmd[1][CMD_W-1:0];
      r.right_cmd = cmd[2][CMD_W-1:0];
      r.travelled = accum;
      return r;
   endfunction

   // Mostly small wheel motion, with jumps and fully random readings as noise.
   function automatic logic [DIST_W-1:0] next_reading(input logic [DIST_W-1:0] pos);
      case ($urandom_range(0, 19))
         0, 1:    return DIST_W'($urandom);
         2:       return pos + DIST_W'($urandom_range(0, 65536)) - DIST_W'(32768);
         default: return pos + DIST_W'($urandom_range(0, 2048)) - DIST_W'(1024);
      endcase
   endfunction

   function automatic void add_csr(input reg_index_type idx, input logic [31:0] value);
      stim_row_type row;
      row = '{kind: ROW_CSR, idx: idx, value: value, default: '0};
      directed_rows.push_back(row);
   endfunction

   function automatic void add_tick(input logic [DIST_W-1:0] rear, left, right,
                                    input logic restart);
      stim_row_type row;
      row = '{kind: ROW_TICK, idx: REG_MOTION_MODE, rear: rear, left: left, right: right,
              restart: restart, default: '0};
      directed_rows.push_back(row);
   endfunction

   // A tick whose result is typed in directly.
   function automatic void add_fixed(input logic [DIST_W-1:0] rear, left, right,
                                     input logic restart,
                                     input logic signed [CMD_W-1:0] rc, lc, ric,
                                     input logic signed [ACC_W-1:0] trav,
                                     input logic reach);
      stim_row_type row;
      row = '{kind: ROW_FIXED, idx: REG_MOTION_MODE, rear: rear, left: left, right: right,
              restart: restart, default: '0};
      row.known = '{rc, lc, ric, trav, reach};
      directed_rows.push_back(row);
   endfunction

   // Offers one tick and records its result once the transfer is accepted.
   task automatic send_tick(input logic [DIST_W-1:0] rear, left, right, input logic restart,
                            input bit fixed, input wheel_result_type known);
      wheel_result_type predicted;
      req_valid          <= 1'b1;
      req_rear_distance  <= rear;
      req_left_distance  <= left;
      req_right_distance <= right;
      req_restart        <= restart;
      do @(posedge clock); while (req_stall);
      predicted = loop_tick(rear, left, right, restart);
      queued_results.push_back(fixed ? known : predicted);
   endtask

   task automatic idle_gap(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Stops the sender and waits until every pending result has been transferred.
   task automatic quiesce();
      req_valid <= 1'b0;
      while (queued_results.size() != 0) @(posedge clock);
   endtask

   // Setup and access cycles of one register write; the bus stays selected afterwards.
   task automatic csr_write(input reg_index_type idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_W'({idx, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_MOTION_MODE:    cfg_mode = mode_type'(value[1:0]);
         REG_AXIS_SELECT:    cfg_axis = value[1:0];
         REG_TARGET_VALUE:   cfg_target = value;
         REG_MAX_SPEED:      cfg_speed_limit = value[SPEED_W-1:0];
         REG_DONE_THRESHOLD: cfg_threshold = value[THR_W-1:0];
         REG_ROTATION_SCALE: cfg_scale = value[SCALE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic csr_release();
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // The receiver switches between stall styles, drawing a new style and run length when its run ends.
   always @(posedge clock) begin
      if (stall_run == 0) begin
         stall_style <= stall_style_type'($urandom_range(0, 3));
         stall_run   <= 8'($urandom_range(16, 160));
      end else begin
         stall_run <= stall_run - 8'd1;
      end
      case (stall_style)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= stall_run[2];
      endcase
   end

   // Compares each result transfer with the oldest pending result.
   always @(posedge clock) begin : result_check
      wheel_result_type got, want;
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;

      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_rear_command, rsp_left_command, rsp_right_command, rsp_travelled,
                 rsp_within_threshold};
         if (queued_results.size() == 0) begin
            if (mismatches < REPORT_LIMIT)
               $display({"%0t: result transfer with nothing pending: ",
                         "rear %0d left %0d right %0d travelled %0d reach %0b"},
                        $time, got.rear_cmd, got.left_cmd, got.right_cmd, got.travelled,
                        got.in_reach);
            mismatches++;
         end else begin
            want = queued_results.pop_front();
            if (got.rear_cmd !== want.rear_cmd || got.left_cmd !== want.left_cmd ||
                got.right_cmd !== want.right_cmd || got.travelled !== want.travelled ||
                got.in_reach !== want.in_reach) begin
               if (mismatches < REPORT_LIMIT)
                  $display({"%0t: mismatch (expected/actual) rear %0d/%0d left %0d/%0d ",
                            "right %0d/%0d travelled %0d/%0d reach %0b/%0b"},
                           $time, want.rear_cmd, got.rear_cmd, want.left_cmd, got.left_cmd,
                           want.right_cmd, got.right_cmd, want.travelled, got.travelled,
                           want.in_reach, got.in_reach);
               mismatches++;
            end
         end
      end
   end

   // Ends the run when nothing has moved on either channel for too long.
   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      logic [DIST_W-1:0] pos [3];
      logic [31:0] value;
      logic restart;
      bit in_config;
      int sent, burst;

      // Directed rows: idle after reset, each mode and axis, extremes and restarts.
      add_fixed(DIST_MAX, DIST_MIN, 24'd0, 1'b0, 0, 0, 0, 0, 1'b0);
      add_fixed(24'd0, 24'hFFFFFF, DIST_MAX, 1'b0, 0, 0, 0, 0, 1'b0);
      add_csr(REG_MOTION_MODE, MODE_DRIVE);
      add_fixed(24'd100, 24'd200, 24'd300, 1'b1, 0, 0, 0, 0, 1'b1);
      add_tick(24'd100, 24'hFFFEC8, 24'd812, 1'b0);
      add_tick(DIST_MAX, DIST_MIN, DIST_MAX, 1'b0);
      add_tick(DIST_MIN, DIST_MAX, DIST_MIN, 1'b0);
      add_csr(REG_TARGET_VALUE, 32'h7FFFFFFF);
      add_csr(REG_MAX_SPEED, 32'd0);
      add_tick(24'd0, 24'h001000, 24'h7F0000, 1'b0);
      add_tick(24'd0, 24'h002000, 24'h7FF000, 1'b0);
      add_csr(REG_MOTION_MODE, MODE_STRAFE);
      add_csr(REG_AXIS_SELECT, AXIS_LEFT);
      add_csr(REG_MAX_SPEED, 32'h7FFF);
      add_csr(REG_TARGET_VALUE, 32'h80000000);
      add_tick(24'h400000, 24'h000000, 24'hC00000, 1'b0);
      add_tick(24'h000100, 24'h000200, 24'h000300, 1'b0);
      add_csr(REG_MOTION_MODE, MODE_ROTATE);
      add_csr(REG_AXIS_SELECT, AXIS_RIGHT);
      add_csr(REG_ROTATION_SCALE, 32'hFFFFFF);
      add_csr(REG_DONE_THRESHOLD, 32'd0);
      // Large turns drive the accumulator into both saturation limits.
      add_tick(24'h3FFFFF, 24'h3FFFFF, 24'h3FFFFF, 1'b0);
      add_tick(24'hC00000, 24'hC00000, 24'hC00000, 1'b0);
      add_fixed(24'h000010, 24'h000020, 24'h000030, 1'b1, 0, 0, 0, 0, 1'b0);
      add_csr(REG_AXIS_SELECT, 32'd3);
      add_csr(REG_DONE_THRESHOLD, 32'hFFFF);
      add_csr(REG_ROTATION_SCALE, 32'd0);
      add_csr(REG_TARGET_VALUE, 32'd0);
      add_tick(24'h001010, 24'hFFF020, 24'h000830, 1'b0);
      add_tick(24'h002010, 24'hFFE020, 24'h000030, 1'b0);
      add_csr(REG_ROTATION_SCALE, SCALE_RST);
      add_csr(REG_TARGET_VALUE, 32'd1000);
      add_tick(24'h002410, 24'hFFE420, 24'h000430, 1'b0);
      add_tick(24'h001410, 24'hFFD420, 24'hFFF430, 1'b0);
      add_csr(REG_MOTION_MODE, MODE_IDLE);
      add_tick(24'h005000, 24'h006000, 24'h007000, 1'b0);
      add_fixed(24'h005100, 24'h006100, 24'h007100, 1'b1, 0, 0, 0, 0, 1'b0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed rows; register writes wait for the block to drain.
      in_config = 1'b0;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            if (!in_config) begin
               quiesce();
               in_config = 1'b1;
            end
            csr_write(directed_rows[i].idx, directed_rows[i].value);
         end else begin
            if (in_config) begin
               csr_release();
               in_config = 1'b0;
            end
            send_tick(directed_rows[i].rear, directed_rows[i].left, directed_rows[i].right,
                      directed_rows[i].restart, directed_rows[i].kind == ROW_FIXED,
                      directed_rows[i].known);
            idle_gap($urandom_range(0, 2));
         end
      end

      // Random phases: new settings, then bursts of ticks; a phase's first tick is usually a restart.
      foreach (pos[k]) pos[k] = DIST_W'($urandom);
      for (int phase = 0; phase < PHASES; phase++) begin
         quiesce();
         value = ($urandom_range(0, 7) == 0) ? 32'(MODE_IDLE) : $urandom_range(1, 3);
         csr_write(REG_MOTION_MODE, value);
         csr_write(REG_AXIS_SELECT, $urandom_range(0, 3));
         case ($urandom_range(0, 5))
            0:       value = 32'd0;
            1:       value = 32'h7FFFFFFF;
            2:       value = 32'h80000000;
            default: value = 32'($urandom_range(0, 40000)) - 32'd20000;
         endcase
         csr_write(REG_TARGET_VALUE, value);
         case ($urandom_range(0, 3))
            0:       value = 32'd0;
            1:       value = 32'd25600;
            2:       value = 32'h7FFF;
            default: value = $urandom_range(0, 32767);
         endcase
         csr_write(REG_MAX_SPEED, value);
         case ($urandom_range(0, 3))
            0:       value = 32'd0;
            1:       value = 32'hFFFF;
            2:       value = 32'd256;
            default: value = $urandom_range(0, 65535);
         endcase
         csr_write(REG_DONE_THRESHOLD, value);
         case ($urandom_range(0, 3))
            0:       value = 32'd0;
            1:       value = 32'hFFFFFF;
            2:       value = 32'(SCALE_RST);
            default: value = $urandom_range(0, 24'hFFFFFF);
         endcase
         csr_write(REG_ROTATION_SCALE, value);
         csr_release();

         sent = 0;
         while (sent < TICKS_PER_PHASE) begin
            burst = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 100)
                                                : $urandom_range(1, 16);
            for (int b = 0; b < burst && sent < TICKS_PER_PHASE; b++) begin
               foreach (pos[k]) pos[k] = next_reading(pos[k]);
               restart = (sent == 0) ? ($urandom_range(0, 4) != 0)
                                     : ($urandom_range(0, 31) == 0);
               send_tick(pos[0], pos[1], pos[2], restart, 1'b0, '0);
               sent++;
            end
            idle_gap($urandom_range(1, 8));
         end
      end

      // Drain, then keep watching for any stray result transfer before the verdict.
      quiesce();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && queued_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/kdpl_pkg.sv
rtl/kiwi_drive_position_loop_top.sv
tb/sv/kiwi_drive_position_loop_top_test.sv
